// ----- sv/sdd_pkg.sv -----
// Shared types and constants for the stream duplicate detector.
package sdd_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Stream payload widths.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 8;

	// Result tdata bit positions.
	localparam int OUT_DUP_BIT = 0;
	localparam int OUT_OVF_BIT = 1;

	// Control bits that travel with a value down the chain.
	typedef struct packed {
		logic valid;   // slot holds a request
		logic last;    // final value of the array
		logic hit;     // matched a stored entry upstream
		logic placed;  // already stored in an upstream cell
	} sdd_slot_t;

endpackage

// ----- sv/sdd_cell.sv -----
// One storage cell of the duplicate detector chain.
module sdd_cell #(
	parameter int VALUE_BITS = sdd_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  sdd_pkg::sdd_slot_t    ctl_in,
	input  logic [VALUE_BITS-1:0] val_in,
	output sdd_pkg::sdd_slot_t    ctl_out,
	output logic [VALUE_BITS-1:0] val_out
);
	import sdd_pkg::*;

	logic [VALUE_BITS-1:0] stored_q;
	logic                  occupied_q;
	sdd_slot_t             ctl_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  match;
	logic                  take;

	// cells fill in order, so an empty cell means no match further on
	assign match = occupied_q && (stored_q == val_in);
	assign take  = ctl_in.valid && !occupied_q && !ctl_in.hit && !ctl_in.placed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q      <= '0;
			occupied_q <= 1'b0;
		end else if (adv) begin
			ctl_q.valid  <= ctl_in.valid;
			ctl_q.last   <= ctl_in.last;
			ctl_q.hit    <= ctl_in.hit | (ctl_in.valid & match);
			ctl_q.placed <= ctl_in.placed | take;
			if (ctl_in.valid) begin
				// last value of an array empties the cell behind it
				if (ctl_in.last) begin
					occupied_q <= 1'b0;
				end else if (take) begin
					occupied_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q <= val_in;
			if (take) begin
				stored_q <= val_in;
			end
		end
	end

	assign ctl_out = ctl_q;
	assign val_out = val_q;

endmodule

// ----- sv/stream_duplicate_detector_core.sv -----
// Top level of the stream duplicate detector: a systolic chain of storage cells.
//
// Each request carries one signed 32-bit array element on s_axis_tdata; s_axis_tlast
// marks the final element of an array. The low VALUE_BITS bits of every element walk
// down a chain of CAPACITY cells, one cell per cycle unless stalled. Each cell holds
// one distinct value of the current array; an element that matches an occupied cell
// is flagged as a duplicate, an element that finds no match is stored in the first
// empty cell, and an element that reaches the end of the chain neither matched nor
// stored marks the set as overflowed. Elements move in order, so every element sees
// all insertions of the elements before it. The last element of an array empties
// each cell as it passes and, at the chain end, yields one result with the sticky
// duplicate and overflow flags; those flags are then cleared for the next array.
// Throughput is one element per cycle while the chain is not stalled. The edge
// that accepts a last element loads the first cell, then CAPACITY - 1 further
// cells and the output register follow. The chain stalls only while a last
// element sits at the chain end and the previous result has not yet been taken.
// Elements that are not last produce no result request.
module stream_duplicate_detector_core #(
	parameter int CAPACITY   = sdd_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = sdd_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [sdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] value_in
	input  logic                           s_axis_tlast,  // last_value
	// master side
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [sdd_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [0] has_duplicate,
	                                                       // [1] store_overflowed,
	                                                       // [7:2] zero
);
	import sdd_pkg::*;

	sdd_slot_t             slot_ctl [0:CAPACITY];
	logic [VALUE_BITS-1:0] slot_val [0:CAPACITY];
	logic [VALUE_BITS-1:0] key;
	logic                  adv;
	sdd_slot_t             tail;
	logic                  tail_ovf;
	logic                  dup_next;
	logic                  ovf_next;

	// sticky flags of the array in progress
	logic                  dup_q;
	logic                  ovf_q;

	// result register
	logic                  out_valid_q;
	logic                  out_dup_q;
	logic                  out_ovf_q;

	// Only the low VALUE_BITS bits of an element take part; wider keys zero-extend.
	generate
		if (VALUE_BITS <= IN_DATA_W) begin : g_key_trunc
			assign key = s_axis_tdata[VALUE_BITS-1:0];
		end else begin : g_key_ext
			assign key = {{(VALUE_BITS-IN_DATA_W){1'b0}}, s_axis_tdata};
		end
	endgenerate

	assign tail = slot_ctl[CAPACITY];

	// Hold the whole chain only when a result is due and the last one is still waiting.
	assign adv = !(out_valid_q && !m_axis_tready && tail.valid && tail.last);
	assign s_axis_tready = adv;

	// Chain head: a fresh element has neither matched nor been placed.
	assign slot_ctl[0] = '{valid: s_axis_tvalid, last: s_axis_tlast,
		hit: 1'b0, placed: 1'b0};
	assign slot_val[0] = key;

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			sdd_cell #(
				.VALUE_BITS(VALUE_BITS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.ctl_in (slot_ctl[i]),
				.val_in (slot_val[i]),
				.ctl_out(slot_ctl[i+1]),
				.val_out(slot_val[i+1])
			);
		end
	endgenerate

	// An element that leaves the chain unmatched and unstored found the set full.
	assign tail_ovf = !tail.hit && !tail.placed;
	assign dup_next = dup_q | tail.hit;
	assign ovf_next = ovf_q | tail_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && tail.valid) begin
				if (tail.last) begin
					out_valid_q <= 1'b1;
					dup_q       <= 1'b0;
					ovf_q       <= 1'b0;
				end else begin
					dup_q <= dup_next;
					ovf_q <= ovf_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.valid && tail.last) begin
			out_dup_q <= dup_next;
			out_ovf_q <= ovf_next;
		end
	end

	always_comb begin
		m_axis_tdata              = '0;
		m_axis_tdata[OUT_DUP_BIT] = out_dup_q;
		m_axis_tdata[OUT_OVF_BIT] = out_ovf_q;
	end
	assign m_axis_tvalid = out_valid_q;

endmodule

// ----- sv/sdd_checker.sv -----
// Port-level checks for the stream duplicate detector, bound to the top level.
module sdd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [sdd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import sdd_pkg::*;

	// a stalled result keeps its flags
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// the chain only holds back requests while a result is blocked
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a blocked result");

	// padding bits of the result stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:2] == '0)
		else $error("result padding not zero");

endmodule

bind stream_duplicate_detector_core sdd_checker u_sdd_checker (.*);
